// ===== hdl/mpd_pkg.sv =====
// Shared types and constants for the MQTT publish deframer.
// Beat and result structs, error codes and header byte constants.
// No dependencies.
`timescale 1ns / 1ps

package mpd_pkg;

  // One received beat: a broker byte and its connection-start flag
  typedef struct packed {
    logic       new_connection;
    logic [7:0] rx_byte;
  } mpd_in_t;

  // Error codes carried with a result
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_OVERSIZE  = 2'd2
  } mpd_err_t;

  // One result: a message byte with its marks, or an error report
  typedef struct packed {
    mpd_err_t   error_code;
    logic       msg_last;
    logic       msg_first;
    logic [7:0] msg_byte;
  } mpd_res_t;

  // Fixed header constants
  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] TYPE_PUBLISH = 8'h30;
  localparam int         LEN_BITS     = 28;

endpackage

// ===== hdl/mpd_in_buf.sv =====
// Two-entry input buffer for the deframer; ready comes from its fill count
// alone, so in_ready has no combinational path from the downstream handshake.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_in_buf
  import mpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  mpd_in_t in_item,
  output logic    head_valid,
  input  logic    head_pop,
  output mpd_in_t head_item
);

  logic [1:0] count;
  mpd_in_t    slot0;
  mpd_in_t    slot1;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slot0;
  assign push       = in_valid && in_ready;
  assign pop        = head_valid && head_pop;

  // Track the number of held beats
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Shift beats toward the head slot
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= in_item;
        end else begin
          slot1 <= in_item;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= in_item;
        end else begin
          slot0 <= slot1;
          slot1 <= in_item;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

// ===== hdl/mpd_parser.sv =====
// Packet parser for the deframer: one parse step per beat between the input
// buffer head and a registered result.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_parser
  import mpd_pkg::*;
#(
  parameter int MSG_DEPTH = 256,
  parameter int RX_DEPTH  = 4096
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  output logic     head_pop,
  input  mpd_in_t  head_item,
  output logic     res_valid,
  input  logic     res_ready,
  output mpd_res_t res
);

  typedef enum logic [2:0] {
    PH_TYPE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_TOPIC_HI = 3'd2,
    PH_TOPIC_LO = 3'd3,
    PH_TOPIC    = 3'd4,
    PH_BODY     = 3'd5,
    PH_SKIP     = 3'd6
  } phase_t;

  // Packet size limits: 1 + digits + length must not exceed RX_DEPTH
  localparam logic [29:0] RX_LIM1 = 30'(RX_DEPTH - 2);
  localparam logic [29:0] RX_LIM2 = 30'(RX_DEPTH - 3);
  localparam logic [29:0] RX_LIM3 = 30'(RX_DEPTH - 4);
  localparam logic [29:0] RX_LIM4 = 30'(RX_DEPTH - 5);
  localparam logic [28:0] MSG_MAX = 29'(MSG_DEPTH - 1);

  phase_t                phase, phase_next, ph_c;
  logic                  is_publish, is_publish_next, pub_c;
  logic [LEN_BITS-1:0]   length_accum, length_accum_next, acc_c;
  logic [2:0]            length_digits, length_digits_next, dig_c;
  logic [LEN_BITS-1:0]   bytes_left, bytes_left_next, left_c;
  logic [15:0]           topic_left, topic_left_next, top_c;
  logic                  message_ok, message_ok_next, ok_c;
  logic                  first_pending, first_pending_next, first_c;
  logic                  halted, halted_next, halt_c;

  logic                  nc;
  logic [7:0]            b;
  logic [LEN_BITS-1:0]   digit_sh;
  logic [LEN_BITS-1:0]   accum_or;
  logic [2:0]            dig_inc;
  logic [29:0]           rx_lim;
  logic [LEN_BITS-1:0]   left_dec;
  logic [LEN_BITS-1:0]   left_sat;
  logic [15:0]           topic_word;
  logic [15:0]           topic_sat;
  logic [16:0]           topic_p1;
  logic [28:0]           msg_diff;
  logic                  step_valid;
  mpd_res_t              step_res;

  assign nc = head_item.new_connection;
  assign b  = head_item.rx_byte;

  // Apply a connection start before parsing this beat
  assign ph_c    = nc ? PH_TYPE : phase;
  assign pub_c   = nc ? 1'b0 : is_publish;
  assign acc_c   = nc ? '0 : length_accum;
  assign dig_c   = nc ? 3'd0 : length_digits;
  assign left_c  = nc ? '0 : bytes_left;
  assign top_c   = nc ? 16'd0 : topic_left;
  assign ok_c    = nc ? 1'b0 : message_ok;
  assign first_c = nc ? 1'b0 : first_pending;
  assign halt_c  = nc ? 1'b0 : halted;

  // Place a length digit in its 7-bit field; lower fields are already filled
  always_comb begin
    unique case (dig_c[1:0])
      2'd0: digit_sh = LEN_BITS'(b[6:0]);
      2'd1: digit_sh = LEN_BITS'(b[6:0]) << 7;
      2'd2: digit_sh = LEN_BITS'(b[6:0]) << 14;
      default: digit_sh = LEN_BITS'(b[6:0]) << 21;
    endcase
  end

  assign accum_or = acc_c | digit_sh;
  assign dig_inc  = dig_c + 3'd1;

  // Pick the size limit for the number of digits taken
  always_comb begin
    unique case (dig_inc)
      3'd1:    rx_lim = RX_LIM1;
      3'd2:    rx_lim = RX_LIM2;
      3'd3:    rx_lim = RX_LIM3;
      default: rx_lim = RX_LIM4;
    endcase
  end

  // Byte counters and message size check
  assign left_dec   = left_c - LEN_BITS'(1);
  assign left_sat   = (left_c != '0) ? left_dec : '0;
  assign topic_sat  = (top_c != 16'd0) ? (top_c - 16'd1) : 16'd0;
  assign topic_word = {top_c[7:0], b};
  assign topic_p1   = {1'b0, topic_word} + 17'd1;
  assign msg_diff   = {1'b0, left_c} - 29'(topic_p1);

  // One parse step
  always_comb begin
    phase_next         = ph_c;
    is_publish_next    = pub_c;
    length_accum_next  = acc_c;
    length_digits_next = dig_c;
    bytes_left_next    = left_c;
    topic_left_next    = top_c;
    message_ok_next    = ok_c;
    first_pending_next = first_c;
    halted_next        = halt_c;
    step_valid         = 1'b0;
    step_res           = '{error_code: ERR_NONE, msg_last: 1'b0, msg_first: 1'b0,
                           msg_byte: 8'd0};
    if (!halt_c) begin
      unique case (ph_c)
        PH_TYPE: begin
          is_publish_next    = ((b & TYPE_MASK) == TYPE_PUBLISH);
          length_accum_next  = '0;
          length_digits_next = 3'd0;
          message_ok_next    = 1'b0;
          first_pending_next = 1'b0;
          phase_next         = PH_LEN;
        end
        PH_LEN: begin
          length_accum_next  = accum_or;
          length_digits_next = dig_inc;
          if (b[7]) begin
            if (dig_inc >= 3'd4) begin
              halted_next         = 1'b1;
              phase_next          = PH_TYPE;
              step_valid          = 1'b1;
              step_res.error_code = ERR_MALFORMED;
            end
          end else if ({2'b00, accum_or} > rx_lim) begin
            halted_next         = 1'b1;
            phase_next          = PH_TYPE;
            step_valid          = 1'b1;
            step_res.error_code = ERR_OVERSIZE;
          end else begin
            bytes_left_next = accum_or;
            if (accum_or == '0) begin
              phase_next = PH_TYPE;
            end else if (pub_c && accum_or >= LEN_BITS'(3)) begin
              phase_next = PH_TOPIC_HI;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_TOPIC_HI: begin
          topic_left_next = 16'(b);
          bytes_left_next = left_dec;
          phase_next      = PH_TOPIC_LO;
        end
        PH_TOPIC_LO: begin
          topic_left_next = topic_word;
          bytes_left_next = left_dec;
          if (!msg_diff[28] && msg_diff != 29'd0 && msg_diff <= MSG_MAX) begin
            message_ok_next    = 1'b1;
            first_pending_next = 1'b1;
            phase_next         = (topic_word != 16'd0) ? PH_TOPIC : PH_BODY;
          end else begin
            phase_next = (left_dec == '0) ? PH_TYPE : PH_SKIP;
          end
        end
        PH_TOPIC: begin
          topic_left_next = topic_sat;
          bytes_left_next = left_sat;
          if (left_sat == '0) begin
            phase_next = PH_TYPE;
          end else if (topic_sat == 16'd0) begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          bytes_left_next    = left_sat;
          first_pending_next = 1'b0;
          if (left_sat == '0) begin
            phase_next = PH_TYPE;
          end
          if (ok_c) begin
            step_valid         = 1'b1;
            step_res.msg_byte  = b;
            step_res.msg_first = first_c;
            step_res.msg_last  = (left_sat == '0);
          end
        end
        default: begin
          bytes_left_next = left_sat;
          phase_next      = (left_sat == '0) ? PH_TYPE : PH_SKIP;
        end
      endcase
    end
  end

  // Take the head beat whenever the result register is free or draining
  assign head_pop = head_valid && (!res_valid || res_ready);

  // Hold parser state and the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TYPE;
      is_publish    <= 1'b0;
      length_accum  <= '0;
      length_digits <= 3'd0;
      bytes_left    <= '0;
      topic_left    <= 16'd0;
      message_ok    <= 1'b0;
      first_pending <= 1'b0;
      halted        <= 1'b0;
      res_valid     <= 1'b0;
    end else if (head_pop) begin
      phase         <= phase_next;
      is_publish    <= is_publish_next;
      length_accum  <= length_accum_next;
      length_digits <= length_digits_next;
      bytes_left    <= bytes_left_next;
      topic_left    <= topic_left_next;
      message_ok    <= message_ok_next;
      first_pending <= first_pending_next;
      halted        <= halted_next;
      res_valid     <= step_valid;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (head_pop && step_valid) begin
      res <= step_res;
    end
  end

endmodule

// ===== hdl/mqtt_publish_deframer_core.sv =====
// Top level of the MQTT publish deframer: input buffer feeding the parser.
// Depends on mpd_pkg, mpd_in_buf and mpd_parser.
//
//   Channel  Dir  Beat contents                                  Marks
//   s_axis   in   tdata: rx_byte; tuser: new_connection          -
//   m_axis   out  tdata: msg_byte; tuser: msg_first, error_code  tlast = msg_last
//
// One input beat per cycle sustained while m_axis_tready is high; an accepted beat is written into the
// input buffer, and its parse step then loads the result register from the buffer head.
// The rate is set by the single parse step between the buffer head and the result.
// Reset (rst, synchronous) returns the parser to the packet type byte and empties the
// input buffer and the result register. s_axis_tready drops only when the two-entry
// input buffer is full, which happens after m_axis_tready has been held low.
`timescale 1ns / 1ps

module mqtt_publish_deframer_core
  import mpd_pkg::*;
#(
  parameter int MSG_DEPTH = 256,
  parameter int RX_DEPTH  = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0] s_axis_tuser,   // [0] new_connection
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] msg_byte
  output logic [2:0] m_axis_tuser,   // [0] msg_first, [2:1] error_code
  output logic       m_axis_tlast
);

  mpd_in_t  in_item;
  mpd_in_t  head_item;
  logic     head_valid;
  logic     head_pop;
  mpd_res_t res;

  assign in_item.rx_byte        = s_axis_tdata;
  assign in_item.new_connection = s_axis_tuser[0];

  // Buffer incoming beats
  mpd_in_buf u_in_buf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_item  (head_item)
  );

  // Parse one beat per cycle into the result register while it is free or draining
  mpd_parser #(
    .MSG_DEPTH (MSG_DEPTH),
    .RX_DEPTH  (RX_DEPTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_item  (head_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // Unpack the result onto the output beat
  assign m_axis_tdata = res.msg_byte;
  assign m_axis_tuser = {res.error_code, res.msg_first};
  assign m_axis_tlast = res.msg_last;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for mqtt_publish_deframer_core: byte stream in, message beats out.
// Directed table then random packets, checked against a local deframer model.
// Depends on mpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import mpd_pkg::*;

  localparam int MSG_DEPTH  = 256;
  localparam int RX_DEPTH   = 4096;
  localparam int RAND_ITEMS = 1450;
  localparam int DIR_ROWS   = 27;
  localparam int CYCLE_CAP  = 500000;
  localparam int HOLD_LEN   = 300;

  // Parser phases of the local model
  typedef enum logic [2:0] {
    P_TYPE, P_LEN, P_TOPIC_HI, P_TOPIC_LO, P_TOPIC, P_BODY, P_SKIP
  } phase_t;

  // One directed row: input beat, and a typed result where one is given
  typedef struct packed {
    logic       nc;
    logic [7:0] data;
    logic       fixed;
    logic       has;
    mpd_res_t   res;
  } row_t;

  localparam mpd_res_t NO_RES = '{ERR_NONE, 1'b0, 1'b0, 8'h00};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0] s_axis_tuser = 1'b0;    // [0] new_connection
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] msg_byte
  logic [2:0] m_axis_tuser;           // [0] msg_first, [2:1] error_code
  logic       m_axis_tlast;

  mqtt_publish_deframer_core #(
    .MSG_DEPTH(MSG_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Model state
  phase_t      ph;
  logic        is_pub;
  logic [27:0] len_acc;
  logic [2:0]  len_digits;
  logic [27:0] bytes_left;
  logic [15:0] topic_left;
  logic        msg_ok;
  logic        first_pend;
  logic        halted;

  mpd_res_t    pending_results[$];
  logic [7:0]  pkt[$];
  int          bytes_sent = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          hold_asks = 0;
  int          hold_done = 0;
  bit          calm = 1'b0;

  task automatic clear_parser();
    ph         = P_TYPE;
    is_pub     = 1'b0;
    len_acc    = '0;
    len_digits = '0;
    bytes_left = '0;
    topic_left = '0;
    msg_ok     = 1'b0;
    first_pend = 1'b0;
    halted     = 1'b0;
  endtask

  // Advance the deframer model by one received byte
  task automatic deframe_byte(input logic [7:0] b, input logic nc,
                              output bit got, output mpd_res_t res);
    logic [63:0] total;
    logic [15:0] tlen;
    logic [27:0] mlen;
    logic        f;
    mpd_err_t    err;
    got = 1'b0;
    res = NO_RES;
    err = ERR_NONE;
    if (nc) clear_parser();
    if (halted) return;
    case (ph)
      P_TYPE: begin
        is_pub     = ((b & TYPE_MASK) == TYPE_PUBLISH);
        len_acc    = '0;
        len_digits = '0;
        msg_ok     = 1'b0;
        first_pend = 1'b0;
        ph         = P_LEN;
      end
      P_LEN: begin
        len_acc    = len_acc + ({21'd0, b[6:0]} << (7 * len_digits[1:0]));
        len_digits = len_digits + 3'd1;
        if (b[7]) begin
          if (len_digits >= 3'd4) err = ERR_MALFORMED;
        end else begin
          total = 64'd1 + len_digits + len_acc;
          if (total > RX_DEPTH) begin
            err = ERR_OVERSIZE;
          end else begin
            bytes_left = len_acc;
            if (bytes_left == 0) ph = P_TYPE;
            else if (is_pub && bytes_left >= 3) ph = P_TOPIC_HI;
            else ph = P_SKIP;
          end
        end
      end
      P_TOPIC_HI: begin
        topic_left = {8'd0, b};
        bytes_left = bytes_left - 28'd1;
        ph         = P_TOPIC_LO;
      end
      P_TOPIC_LO: begin
        tlen       = {topic_left[7:0], b};
        topic_left = tlen;
        bytes_left = bytes_left - 28'd1;
        if (tlen > bytes_left) begin
          ph = (bytes_left == 0) ? P_TYPE : P_SKIP;
        end else begin
          mlen = bytes_left - tlen;
          if (mlen >= 1 && mlen <= MSG_DEPTH - 1) begin
            msg_ok     = 1'b1;
            first_pend = 1'b1;
            ph         = (topic_left != 0) ? P_TOPIC : P_BODY;
          end else begin
            ph = (bytes_left == 0) ? P_TYPE : P_SKIP;
          end
        end
      end
      P_TOPIC: begin
        if (topic_left != 0) topic_left = topic_left - 16'd1;
        if (bytes_left != 0) bytes_left = bytes_left - 28'd1;
        if (topic_left == 0) ph = P_BODY;
        if (bytes_left == 0) ph = P_TYPE;
      end
      P_BODY: begin
        f = first_pend;
        if (bytes_left != 0) bytes_left = bytes_left - 28'd1;
        first_pend = 1'b0;
        if (bytes_left == 0) ph = P_TYPE;
        if (msg_ok) begin
          got           = 1'b1;
          res.msg_byte  = b;
          res.msg_first = f;
          res.msg_last  = (bytes_left == 0);
        end
      end
      default: begin
        if (bytes_left != 0) bytes_left = bytes_left - 28'd1;
        ph = (bytes_left == 0) ? P_TYPE : P_SKIP;
      end
    endcase
    // Report the error and halt until a new connection
    if (err != ERR_NONE) begin
      halted         = 1'b1;
      ph             = P_TYPE;
      got            = 1'b1;
      res.error_code = err;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat from a falling edge, hold it until accepted, then predict
  task automatic offer_byte(input logic [7:0] b, input logic nc, input logic fixed,
                            input logic has, input mpd_res_t fixed_res);
    int       gap;
    bit       got;
    mpd_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = nc;
    do @(posedge clk); while (!s_axis_tready);
    deframe_byte(b, nc, got, res);
    if (fixed) begin
      if (has) pending_results.push_back(fixed_res);
    end else if (got) begin
      pending_results.push_back(res);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // Append a remaining length, optionally with padding digits
  task automatic append_len(input int unsigned r, input int pad);
    int          digits;
    int unsigned v;
    logic [7:0]  d;
    digits = 1;
    v      = r >> 7;
    while (v != 0) begin
      digits++;
      v = v >> 7;
    end
    digits = digits + pad;
    if (digits > 4) digits = 4;
    for (int i = 0; i < digits; i++) begin
      d = 8'(r & 127);
      if (i < digits - 1) d[7] = 1'b1;
      pkt.push_back(d);
      r = r >> 7;
    end
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk) begin : result_check
    mpd_res_t got;
    mpd_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.error_code = mpd_err_t'(m_axis_tuser[2:1]);
      got.msg_last   = m_axis_tlast;
      got.msg_first  = m_axis_tuser[0];
      got.msg_byte   = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %02h first %0d last %0d err %0d",
                   got.msg_byte, got.msg_first, got.msg_last, got.error_code);
      end else begin
        want = pending_results.pop_front();
        if (got.msg_byte !== want.msg_byte || got.msg_first !== want.msg_first ||
            got.msg_last !== want.msg_last || got.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp byte %02h first %0d last %0d err %0d,",
                     want.msg_byte, want.msg_first, want.msg_last, want.error_code,
                     " got byte %02h first %0d last %0d err %0d",
                     got.msg_byte, got.msg_first, got.msg_last, got.error_code);
        end
      end
    end
  end

  // Drive output ready: random stalls, ready runs, and long hold-offs on request
  initial begin : result_sink
    int stall;
    int run;
    int hold;
    int r;
    stall = 0;
    run   = 0;
    hold  = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold = HOLD_LEN;
        hold_done++;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if (run > 0) begin
          run--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 8) run = $urandom_range(50, 200);
          else if (r >= 95) stall = $urandom_range(8, 40);
          else if (r >= 75) stall = $urandom_range(1, 3);
        end
      end
    end
  end

  // Stimulus: directed table, then random packets
  initial begin : stimulus
    row_t        dir_tbl [DIR_ROWS];
    int          kind;
    int          tlen;
    int          mlen;
    int unsigned rem;
    int          drain;
    bit          second_hold;
    logic        nc0;
    logic [7:0]  t8;

    dir_tbl = '{
      // publish, topic "a", body 00 ff
      '{1'b1, 8'h30, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h05, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h01, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h61, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_RES},
      // empty packet
      '{1'b0, 8'hC0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
      // non-publish packet, skipped
      '{1'b0, 8'h2F, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h02, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hAA, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h55, 1'b0, 1'b0, NO_RES},
      // fourth length digit with the continuation bit set
      '{1'b0, 8'h3F, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF, 1'b1, 1'b1, '{ERR_MALFORMED, 1'b0, 1'b0, 8'h00}},
      // halted: ignored
      '{1'b0, 8'h30, 1'b1, 1'b0, NO_RES},
      // oversize by one byte
      '{1'b1, 8'h30, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFE, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h1F, 1'b1, 1'b1, '{ERR_OVERSIZE, 1'b0, 1'b0, 8'h00}},
      // one-byte message, empty topic
      '{1'b1, 8'h31, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h03, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h41, 1'b1, 1'b1, '{ERR_NONE, 1'b1, 1'b1, 8'h41}}
    };
    second_hold = 1'b0;
    clear_parser();

    // Hold reset, release on a falling edge
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tbl[i])
      offer_byte(dir_tbl[i].data, dir_tbl[i].nc, dir_tbl[i].fixed, dir_tbl[i].has,
                 dir_tbl[i].res);

    // Fill the block while the output is held off
    hold_asks++;

    while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
      if (!second_hold && bytes_sent > DIR_ROWS + RAND_ITEMS / 2) begin
        hold_asks++;
        second_hold = 1'b1;
      end
      pkt.delete();
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      t8   = 8'($urandom);
      if (kind < 60) begin
        // well-formed publish, random content
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        case ($urandom_range(0, 19))
          0:       mlen = MSG_DEPTH - 1;
          1:       mlen = MSG_DEPTH;
          2:       mlen = 0;
          3:       mlen = $urandom_range(13, MSG_DEPTH - 1);
          default: mlen = $urandom_range(1, 12);
        endcase
        rem = 2 + tlen + mlen;
        pkt.push_back({4'h3, t8[3:0]});
        append_len(rem, ($urandom_range(0, 9) == 0) ? 1 : 0);
        pkt.push_back(8'(tlen >> 8));
        pkt.push_back(8'(tlen & 255));
        repeat (tlen + mlen) pkt.push_back(8'($urandom));
      end else if (kind < 75) begin
        // other packet type, skipped
        if (t8[7:4] == 4'h3) t8[7:4] = 4'hB;
        pkt.push_back(t8);
        rem = $urandom_range(0, 8);
        append_len(rem, 0);
        repeat (rem) pkt.push_back(8'($urandom));
      end else if (kind < 80) begin
        // publish too short to hold a topic length
        pkt.push_back({4'h3, t8[3:0]});
        rem = $urandom_range(0, 2);
        append_len(rem, 0);
        repeat (rem) pkt.push_back(8'($urandom));
      end else if (kind < 85) begin
        // topic longer than the packet
        pkt.push_back({4'h3, t8[3:0]});
        rem  = $urandom_range(3, 10);
        tlen = rem - 2 + $urandom_range(1, 300);
        append_len(rem, 0);
        pkt.push_back(8'(tlen >> 8));
        pkt.push_back(8'(tlen & 255));
        repeat (rem - 2) pkt.push_back(8'($urandom));
      end else if (kind < 89) begin
        // length whose fourth digit still has the continuation bit set
        pkt.push_back(t8);
        repeat (4) pkt.push_back(8'(8'h80 | $urandom_range(0, 127)));
      end else if (kind < 93) begin
        // oversize packet: stop at the length
        pkt.push_back(t8);
        rem = $urandom_range(0, 1) ? $urandom_range(RX_DEPTH - 2, RX_DEPTH + 100)
                                   : $urandom_range(RX_DEPTH + 100, 28'hFFFFFFF);
        append_len(rem, 0);
      end else begin
        // raw noise
        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      end
      // Resync on a new connection when the parser is not at a packet start
      nc0 = (ph != P_TYPE) || halted || ($urandom_range(0, 32) == 0);
      foreach (pkt[i])
        offer_byte(pkt[i], (i == 0) ? nc0 : ($urandom_range(0, 299) == 0),
                   1'b0, 1'b0, NO_RES);
    end
    s_axis_tvalid = 1'b0;

    // Drain outstanding results, then let the pipeline settle
    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d predicted results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
